### src/rms_pkg.sv
// Shared types, widths and codes for the running mean / deviation block.
// Used by rms_iter_unit and running_mean_stdev; depends on nothing else.
package rms_pkg;

    localparam int SAMPLE_BITS = 32;
    localparam int COUNT_BITS  = 32;

    // wide numerator / square width and the shared subtractor width
    localparam int WIDE_BITS = 2 * SAMPLE_BITS;
    localparam int SUB_BITS  = (COUNT_BITS + 1 > SAMPLE_BITS + 2) ?
                               COUNT_BITS + 1 : SAMPLE_BITS + 2;
    localparam int ITER_BITS = $clog2(WIDE_BITS + 1);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    localparam logic [1:0] ACT_IDLE      = 2'd0;
    localparam logic [1:0] ACT_CLEAR     = 2'd1;
    localparam logic [1:0] ACT_ACCUM     = 2'd2;
    localparam logic [1:0] ACT_CLEAR_ACC = 2'd3;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic [1:0]                    action;
    } t_in_word;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] mean;
        logic [SAMPLE_BITS-1:0]        std_dev;
        logic [COUNT_BITS-1:0]         samples_seen;
    } t_out_word;

    typedef enum logic [0:0] {
        OP_DIV  = 1'b0,
        OP_SQRT = 1'b1
    } t_iter_op;

    typedef struct packed {
        logic                 start;
        t_iter_op             op;
        logic [ITER_BITS-1:0] iters;
    } t_iter_req;

    typedef struct packed {
        logic                   done;
        logic [WIDE_BITS-1:0]   quot;
        logic [SAMPLE_BITS-1:0] root;
    } t_iter_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MEAN_GO,
        S_MEAN_WAIT,
        S_MUL_S2,
        S_S2_GO,
        S_S2_WAIT,
        S_MUL_D2,
        S_D2_GO,
        S_D2_WAIT,
        S_SQ_GO,
        S_SQ_WAIT,
        S_DONE
    } t_state;

endpackage

### src/rms_iter_unit.sv
// Shared restoring divide / square-root unit, one quotient or root bit per cycle.
// Depends on rms_pkg for widths and the request / response structs.
module rms_iter_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  rms_pkg::t_iter_req                    i_req,
    input  logic [rms_pkg::WIDE_BITS-1:0]         i_num,
    input  logic [rms_pkg::COUNT_BITS-1:0]        i_den,
    output rms_pkg::t_iter_rsp                    o_rsp
);
    import rms_pkg::*;

    logic                   r_busy;
    logic                   r_done;
    t_iter_op               r_op;
    logic [ITER_BITS-1:0]   r_left;
    logic [WIDE_BITS-1:0]   r_work;
    logic [SUB_BITS-1:0]    r_rem;
    logic [SAMPLE_BITS-1:0] r_root;
    logic [COUNT_BITS-1:0]  r_den;

    logic [SUB_BITS-1:0]    shifted;
    logic [SUB_BITS-1:0]    trial;
    logic [SUB_BITS:0]      diff;
    logic                   ge;

    // one compare / subtract serves both operations
    always_comb begin
        if (r_op == OP_SQRT) begin
            shifted = {r_rem[SUB_BITS-3:0], r_work[WIDE_BITS-1 -: 2]};
            trial   = SUB_BITS'({r_root, 2'b01});
        end else begin
            shifted = {r_rem[SUB_BITS-2:0], r_work[WIDE_BITS-1]};
            trial   = SUB_BITS'(r_den);
        end
        diff = {1'b0, shifted} - {1'b0, trial};
        ge   = ~diff[SUB_BITS];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_left == ITER_BITS'(1));
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_left == ITER_BITS'(1))) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_op   <= i_req.op;
            r_left <= i_req.iters;
            r_work <= i_num;
            r_rem  <= '0;
            r_root <= '0;
            r_den  <= i_den;
        end else if (r_busy) begin
            r_left <= r_left - 1'b1;
            r_rem  <= ge ? diff[SUB_BITS-1:0] : shifted;
            if (r_op == OP_SQRT) begin
                r_work <= {r_work[WIDE_BITS-3:0], 2'b00};
                r_root <= {r_root[SAMPLE_BITS-2:0], ge};
            end else begin
                r_work <= {r_work[WIDE_BITS-2:0], ge};
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_work;
    assign o_rsp.root = r_root;

endmodule

### src/running_mean_stdev.sv
// Running mean and sample standard deviation (Welford), signed Q16.16 samples.
// Depends on rms_pkg and rms_iter_unit.
//
// Input channel: i_valid / o_stall carry one word (sample, action) per item.
// Output channel: o_valid / i_stall carry one word (mean, std_dev, samples_seen)
// per item. Every input word yields exactly one output word, in order.
// Actions: idle reports the state, clear zeroes it, accumulate adds the sample,
// clear-then-accumulate does both.
// Sequence: idle and clear go from accept straight to S_DONE, which loads the output
// register once it is free. Accumulate runs one SAMPLE_BITS-step divide for the
// mean, two 2*SAMPLE_BITS-step divides for the variance terms and a SAMPLE_BITS-step
// square root on the one shared divide / root unit, plus a shared 32x32 multiplier
// for the two squares. The first sample after a clear skips the variance; a variance
// too large for the root skips the square root and saturates the deviation.
// o_stall is high while an item is in work; one item is handled at a time.
// The output register holds a finished word while i_stall is high; the block
// still accepts the next item meanwhile and waits at its end only if the
// previous word has not been taken yet.
// Reset (synchronous, active low) zeroes mean, deviation and count and empties
// the output register.
module running_mean_stdev (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  rms_pkg::t_in_word  i_data,
    output logic               o_valid,
    input  logic               i_stall,
    output rms_pkg::t_out_word o_data
);
    import rms_pkg::*;

    t_state                 r_state, n_state;
    logic [SAMPLE_BITS-1:0] r_mean, n_mean;
    logic [SAMPLE_BITS-1:0] r_dev, n_dev;
    logic [COUNT_BITS-1:0]  r_count, n_count;
    logic [SAMPLE_BITS-1:0] r_mag, n_mag;
    logic                   r_neg, n_neg;
    logic [WIDE_BITS-1:0]   r_prod, n_prod;
    logic [WIDE_BITS:0]     r_var, n_var;
    logic                   r_out_valid, n_out_valid;
    t_out_word              r_out, n_out;

    logic                   act_clr;
    logic                   act_acc;
    logic [SAMPLE_BITS-1:0] base_mean;
    logic [COUNT_BITS-1:0]  base_count;
    logic [COUNT_BITS-1:0]  inc_count;
    logic                   x_lt_m;
    logic [SAMPLE_BITS-1:0] x_mag;
    logic [SAMPLE_BITS-1:0] mul_a;
    logic [WIDE_BITS-1:0]   mul_res;
    logic                   out_free;
    logic                   count_le1;

    t_iter_req              it_req;
    logic [WIDE_BITS-1:0]   it_num;
    logic [COUNT_BITS-1:0]  it_den;
    t_iter_rsp              it_rsp;

    rms_iter_unit u_iter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (it_req),
        .i_num   (it_num),
        .i_den   (it_den),
        .o_rsp   (it_rsp)
    );

    always_comb begin
        case (i_data.action)
            ACT_IDLE:      begin act_clr = 1'b0; act_acc = 1'b0; end
            ACT_CLEAR:     begin act_clr = 1'b1; act_acc = 1'b0; end
            ACT_ACCUM:     begin act_clr = 1'b0; act_acc = 1'b1; end
            ACT_CLEAR_ACC: begin act_clr = 1'b1; act_acc = 1'b1; end
            default:       begin act_clr = 1'b0; act_acc = 1'b0; end
        endcase
    end

    // state seen by the new sample, after an optional clear
    assign base_mean  = act_clr ? '0 : r_mean;
    assign base_count = act_clr ? '0 : r_count;
    assign inc_count  = (base_count == COUNT_MAX) ? base_count : base_count + 1'b1;
    assign x_lt_m     = $signed(i_data.sample) < $signed(base_mean);
    assign x_mag      = x_lt_m ? base_mean - SAMPLE_BITS'(i_data.sample)
                               : SAMPLE_BITS'(i_data.sample) - base_mean;

    assign mul_a     = (r_state == S_MUL_S2) ? r_dev : r_mag;
    assign mul_res   = WIDE_BITS'(mul_a) * WIDE_BITS'(mul_a);
    assign out_free  = !r_out_valid || !i_stall;
    assign count_le1 = (r_count[COUNT_BITS-1:1] == '0);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:      if (i_valid) n_state = act_acc ? S_MEAN_GO : S_DONE;
            S_MEAN_GO:   n_state = S_MEAN_WAIT;
            S_MEAN_WAIT: if (it_rsp.done) n_state = count_le1 ? S_DONE : S_MUL_S2;
            S_MUL_S2:    n_state = S_S2_GO;
            S_S2_GO:     n_state = S_S2_WAIT;
            S_S2_WAIT:   if (it_rsp.done) n_state = S_MUL_D2;
            S_MUL_D2:    n_state = S_D2_GO;
            S_D2_GO:     n_state = S_D2_WAIT;
            S_D2_WAIT:   if (it_rsp.done) n_state = S_SQ_GO;
            S_SQ_GO:     n_state = r_var[WIDE_BITS] ? S_DONE : S_SQ_WAIT;
            S_SQ_WAIT:   if (it_rsp.done) n_state = S_DONE;
            S_DONE:      if (out_free) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // datapath and unit control
    always_comb begin
        n_mean      = r_mean;
        n_dev       = r_dev;
        n_count     = r_count;
        n_mag       = r_mag;
        n_neg       = r_neg;
        n_prod      = r_prod;
        n_var       = r_var;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_stall;
        it_req      = '0;
        it_num      = '0;
        it_den      = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_mean  = base_mean;
                    n_count = act_acc ? inc_count : base_count;
                    n_dev   = act_clr ? '0 : r_dev;
                    n_mag   = x_mag;
                    n_neg   = x_lt_m;
                end
            end
            S_MEAN_GO: begin
                it_req.start = 1'b1;
                it_req.op    = OP_DIV;
                it_req.iters = ITER_BITS'(SAMPLE_BITS);
                it_num       = {r_mag, {SAMPLE_BITS{1'b0}}};
                it_den       = r_count;
            end
            S_MEAN_WAIT: begin
                if (it_rsp.done) begin
                    n_mean = r_neg ? r_mean - it_rsp.quot[SAMPLE_BITS-1:0]
                                   : r_mean + it_rsp.quot[SAMPLE_BITS-1:0];
                    if (count_le1) n_dev = '0;
                end
            end
            S_MUL_S2, S_MUL_D2: begin
                n_prod = mul_res;
            end
            S_S2_GO: begin
                it_req.start = 1'b1;
                it_req.op    = OP_DIV;
                it_req.iters = ITER_BITS'(WIDE_BITS);
                it_num       = r_prod;
                it_den       = r_count - 1'b1;
            end
            S_S2_WAIT: begin
                if (it_rsp.done) n_var = {1'b0, r_prod - it_rsp.quot};
            end
            S_D2_GO: begin
                it_req.start = 1'b1;
                it_req.op    = OP_DIV;
                it_req.iters = ITER_BITS'(WIDE_BITS);
                it_num       = r_prod;
                it_den       = r_count;
            end
            S_D2_WAIT: begin
                if (it_rsp.done) n_var = r_var + {1'b0, it_rsp.quot};
            end
            S_SQ_GO: begin
                // a variance of 2^(2*SAMPLE_BITS) or more has a root past the range
                if (r_var[WIDE_BITS]) begin
                    n_dev = '1;
                end else begin
                    it_req.start = 1'b1;
                    it_req.op    = OP_SQRT;
                    it_req.iters = ITER_BITS'(SAMPLE_BITS);
                    it_num       = r_var[WIDE_BITS-1:0];
                end
            end
            S_SQ_WAIT: begin
                if (it_rsp.done) n_dev = it_rsp.root;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid        = 1'b1;
                    n_out.mean         = r_mean;
                    n_out.std_dev      = r_dev;
                    n_out.samples_seen = r_count;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_mean      <= '0;
            r_dev       <= '0;
            r_count     <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_mean      <= n_mean;
            r_dev       <= n_dev;
            r_count     <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag  <= n_mag;
        r_neg  <= n_neg;
        r_prod <= n_prod;
        r_var  <= n_var;
        r_out  <= n_out;
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    a_dev_zero_small_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && count_le1) |-> (r_dev == '0))
        else $error("deviation nonzero with fewer than two samples");

    a_accum_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && act_acc) |=> (r_count != '0))
        else $error("accumulate left the count at zero");

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        it_rsp.done |-> (r_state == S_MEAN_WAIT || r_state == S_S2_WAIT ||
                         r_state == S_D2_WAIT || r_state == S_SQ_WAIT))
        else $error("shared unit finished outside a wait state");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && out_free) |=> (o_valid && r_state == S_IDLE))
        else $error("finished word not loaded into the output register");

endmodule
